>>> rtl/lrulist_pkg.sv
// Shared types and constants for the LRU order list engine.
// Used by lrulist_cell and lru_order_list_engine_core; depends on nothing.
package lrulist_pkg;

    localparam int LRL_SLOTS = 64;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_EVICT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        COP_NOP,
        COP_APPEND,
        COP_REMOVE,
        COP_MOVE,
        COP_SHIFT
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_EVICT
    } t_state;

    typedef struct packed {
        t_cell_op            op;
        logic [SLOT_W-1:0]   key;
    } t_cell_cmd;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                valid;
    } t_cell_data;

    typedef struct packed {
        logic [SLOT_W-1:0]   evicted_slot;
        logic                evicted_valid;
        logic                last_result;
        logic [COUNT_W-1:0]  list_count;
        logic                error_flag;
    } t_result;

endpackage

>>> rtl/lrulist_cell.sv
// One position of the replacement-order list: holds a slot number and a valid bit.
// Depends on lrulist_pkg; a row of these cells forms the list, head at cell 0.
module lrulist_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lrulist_pkg::t_cell_cmd i_cmd,
    input  logic                   i_left_valid,
    input  logic                   i_left_shift,
    input  lrulist_pkg::t_cell_data i_right,
    output lrulist_pkg::t_cell_data o_data,
    output logic                   o_shift
);
    import lrulist_pkg::*;

    logic [SLOT_W-1:0] r_slot;
    logic              r_valid;
    logic [SLOT_W-1:0] n_slot;
    logic              n_valid;
    logic              w_match;

    assign w_match = r_valid && (r_slot == i_cmd.key)
                     && (i_cmd.op == COP_REMOVE || i_cmd.op == COP_MOVE);
    // Every cell at or behind the matching one closes the gap.
    assign o_shift = i_left_shift || w_match;

    always_comb begin
        n_slot  = r_slot;
        n_valid = r_valid;
        unique case (i_cmd.op)
            COP_NOP: begin
            end
            COP_APPEND: begin
                if (!r_valid && i_left_valid) begin
                    n_slot  = i_cmd.key;
                    n_valid = 1'b1;
                end
            end
            COP_REMOVE: begin
                if (o_shift) begin
                    n_slot  = i_right.slot;
                    n_valid = i_right.valid;
                end
            end
            COP_MOVE: begin
                // The last occupied cell takes the moved slot as the new tail.
                if (o_shift && r_valid) begin
                    n_slot = i_right.valid ? i_right.slot : i_cmd.key;
                end
            end
            COP_SHIFT: begin
                n_slot  = i_right.slot;
                n_valid = i_right.valid;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data.slot  = r_slot;
    assign o_data.valid = r_valid;

endmodule

>>> rtl/lru_order_list_engine_core.sv
// LRU order list engine: keeps the replacement order of up to SLOTS entry slots.
// Top level; depends on lrulist_pkg and lrulist_cell.
//
// Usage: commands arrive on the input channel (i_valid / o_stall) with i_cmd,
// i_entry_slot and i_evict_limit; results leave on the output channel
// (o_valid / i_stall). A transaction happens at a clock edge where valid is
// high and stall is low. The list is a row of SLOTS cells, head at cell 0.
// Append, remove and move-to-tail are done in the acceptance cycle by the cell
// row and produce one result, registered into the output queue; while o_stall
// stays low, commands can follow each other every cycle.
// A bulk evict of n entries is accepted, then one slot per cycle is shifted out
// of the head cell while the queue is not full, the last result flagged. An
// evict of zero entries gives one empty result like the other commands.
// Results go through a two-entry output queue, so a command is still taken
// while one finished result waits; when the receiver stalls and the queue is
// full, o_stall rises and eviction pauses with no result lost.
// Synchronous active-low reset empties the list and the queue.
module lru_order_list_engine_core #(
    parameter int SLOTS = lrulist_pkg::LRL_SLOTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_cmd,
    input  logic [lrulist_pkg::SLOT_W-1:0]     i_entry_slot,
    input  logic [lrulist_pkg::COUNT_W-1:0]    i_evict_limit,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [lrulist_pkg::SLOT_W-1:0]     o_evicted_slot,
    output logic                               o_evicted_valid,
    output logic                               o_last_result,
    output logic [lrulist_pkg::COUNT_W-1:0]    o_list_count,
    output logic                               o_error_flag
);
    import lrulist_pkg::*;

    t_state             r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COUNT_W-1:0] r_left, n_left;

    t_result            r_q [2];
    logic               r_wr_ptr, r_rd_ptr;
    logic [1:0]         r_qcnt;

    t_cell_cmd          w_cell_cmd;
    t_cell_data         w_cell [SLOTS];
    logic               w_shift [SLOTS];
    logic [SLOTS-1:0]   w_valid;
    logic [SLOTS:0]     w_valid_inc;

    t_cmd               w_cmd;
    logic               w_full, w_accept, w_in_range, w_push, w_pop;
    logic [COUNT_W-1:0] w_evict_n;
    t_result            w_res;

    assign w_cmd      = t_cmd'(i_cmd);
    assign w_full     = (r_qcnt == 2'd2);
    assign o_stall    = (r_state != ST_IDLE) || w_full;
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = {1'b0, i_entry_slot} < COUNT_W'(SLOTS);
    assign w_evict_n  = (i_evict_limit < r_count) ? i_evict_limit : r_count;

    // Cell row.
    for (genvar g = 0; g < SLOTS; g++) begin : g_cells
        logic       w_lv;
        logic       w_ls;
        t_cell_data w_rt;
        if (g == 0) begin : g_head
            assign w_lv = 1'b1;
            assign w_ls = 1'b0;
        end else begin : g_body
            assign w_lv = w_cell[g-1].valid;
            assign w_ls = w_shift[g-1];
        end
        if (g == SLOTS - 1) begin : g_tail
            assign w_rt = '0;
        end else begin : g_inner
            assign w_rt = w_cell[g+1];
        end
        lrulist_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cell_cmd),
            .i_left_valid (w_lv),
            .i_left_shift (w_ls),
            .i_right      (w_rt),
            .o_data       (w_cell[g]),
            .o_shift      (w_shift[g])
        );
        assign w_valid[g] = w_cell[g].valid;
    end

    assign w_valid_inc = {1'b0, w_valid} + (SLOTS+1)'(1);

    // Next state, count and eviction counter.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_left  = r_left;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_APPEND: begin
                            if (w_in_range && r_count < COUNT_W'(SLOTS)) begin
                                n_count = r_count + COUNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (r_count != '0 && w_in_range) begin
                                n_count = r_count - COUNT_W'(1);
                            end
                        end
                        CMD_MOVE: begin
                        end
                        CMD_EVICT: begin
                            if (w_evict_n != '0) begin
                                n_left  = w_evict_n;
                                n_count = r_count - w_evict_n;
                                n_state = ST_EVICT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVICT: begin
                if (!w_full) begin
                    n_left = r_left - COUNT_W'(1);
                    if (r_left == COUNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Cell commands and results.
    always_comb begin
        w_cell_cmd.op  = COP_NOP;
        w_cell_cmd.key = i_entry_slot;
        w_push         = 1'b0;
        w_res          = '0;
        w_res.last_result = 1'b1;
        w_res.list_count  = n_count;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_APPEND: begin
                            w_push = 1'b1;
                            if (w_in_range && r_count < COUNT_W'(SLOTS)) begin
                                w_cell_cmd.op = COP_APPEND;
                            end
                        end
                        CMD_REMOVE, CMD_MOVE: begin
                            w_push = 1'b1;
                            if (r_count == '0) begin
                                w_res.error_flag = 1'b1;
                            end else if (w_in_range) begin
                                w_cell_cmd.op = (w_cmd == CMD_MOVE) ? COP_MOVE : COP_REMOVE;
                            end
                        end
                        CMD_EVICT: begin
                            w_push = (w_evict_n == '0);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EVICT: begin
                if (!w_full) begin
                    w_cell_cmd.op       = COP_SHIFT;
                    w_push              = 1'b1;
                    w_res.evicted_slot  = w_cell[0].slot;
                    w_res.evicted_valid = 1'b1;
                    w_res.last_result   = (r_left == COUNT_W'(1));
                end
            end
            default: begin
            end
        endcase
    end

    assign w_pop = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_res;
        end
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_qcnt   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_left  <= n_left;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_qcnt <= r_qcnt + 2'(w_push) - 2'(w_pop);
        end
    end

    assign o_valid         = (r_qcnt != 2'd0);
    assign o_evicted_slot  = r_q[r_rd_ptr].evicted_slot;
    assign o_evicted_valid = r_q[r_rd_ptr].evicted_valid;
    assign o_last_result   = r_q[r_rd_ptr].last_result;
    assign o_list_count    = r_q[r_rd_ptr].list_count;
    assign o_error_flag    = r_q[r_rd_ptr].error_flag;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt != 2'd3)
        else $error("output queue count out of range");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(w_valid_inc))
        else $error("occupied cells are not packed toward the head");

    a_evict_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EVICT |-> r_left != '0)
        else $error("eviction running with nothing left to evict");

    a_evict_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EVICT && w_push && w_res.last_result) |=> r_state == ST_IDLE)
        else $error("eviction did not finish after its last result");

endmodule
